// ===== sv/hcd_pkg.sv =====
package hcd_pkg;

  // Fixed field widths of the transactions.
  localparam int PIX_W = 32;
  localparam int DVD_W = 48;
  localparam int DVS_W = 32;
  localparam int Q_ONE = 65536;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pixel_out;
    logic [15:0]        iterations_done;
    logic [2:0]         stop_reason;
    logic [5:0]         peak_row;
    logic [5:0]         peak_col;
    logic signed [31:0] peak_value;
  } out_item_t;

  localparam logic [2:0] CMD_WR_MAP   = 3'd0;
  localparam logic [2:0] CMD_WR_BEAM  = 3'd1;
  localparam logic [2:0] CMD_RUN      = 3'd2;
  localparam logic [2:0] CMD_RD_CLEAN = 3'd3;
  localparam logic [2:0] CMD_RD_RES   = 3'd4;

  localparam logic [2:0] REG_LOOP_GAIN = 3'd0;
  localparam logic [2:0] REG_NOISE     = 3'd1;
  localparam logic [2:0] REG_MAX_ITER  = 3'd2;
  localparam logic [2:0] REG_AVG_FACT  = 3'd3;
  localparam logic [2:0] REG_POS_ONLY  = 3'd4;

  localparam logic [2:0] STOP_AVERAGE   = 3'd0;
  localparam logic [2:0] STOP_NOISE     = 3'd1;
  localparam logic [2:0] STOP_ITER      = 3'd2;
  localparam logic [2:0] STOP_NOT_FALL  = 3'd3;
  localparam logic [2:0] STOP_BEAM_ZERO = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_FIN,
    ST_SWEEP,
    ST_CHK0,
    ST_CHK1,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_ADDRD,
    ST_ADDWR,
    ST_DONE
  } hcd_state_t;

  typedef enum logic [1:0] {
    SW_BEAM,
    SW_MAP,
    SW_SUB
  } hcd_sweep_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

endpackage

// ===== sv/hcd_div.sv =====
module hcd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hcd_pkg::DVD_W-1:0]    dividend,
  input  logic [hcd_pkg::DVS_W-1:0]    divisor,
  output logic                         done,
  output logic [hcd_pkg::DVD_W-1:0]    quotient
);
  import hcd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DVS_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/hcd_peak.sv =====
module hcd_peak #(
  parameter int AW = 12,
  parameter int RW = 6,
  parameter int CW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  logic                vld,
  input  logic                pos_only,
  input  logic signed [31:0]  val,
  input  logic [AW-1:0]       k,
  input  logic [RW-1:0]       row,
  input  logic [CW-1:0]       col,
  output logic signed [31:0]  best_val,
  output logic [AW-1:0]       best_k,
  output logic [RW-1:0]       best_row,
  output logic [CW-1:0]       best_col
);
  import hcd_pkg::*;

  logic               have_r, have_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic               better;

  // Strictly greater wins, so the first pixel in raster order keeps ties.
  always_comb begin
    better   = pos_only ? (val > val_r) : (mag32(val) > mag32(val_r));
    have_nxt = have_r;
    val_nxt  = val_r;
    k_nxt    = k_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (clr) begin
      have_nxt = 1'b0;
    end else if (vld && (!have_r || better)) begin
      have_nxt = 1'b1;
      val_nxt  = val;
      k_nxt    = k;
      row_nxt  = row;
      col_nxt  = col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
    val_r <= val_nxt;
    k_r   <= k_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  assign best_val = val_r;
  assign best_k   = k_r;
  assign best_row = row_r;
  assign best_col = col_r;

endmodule

// ===== sv/hogbom_clean_deconvolver.sv =====
// Hogbom CLEAN deconvolver. Load the dirty map and dirty beam one pixel per transaction,
// issue a run, then read back clean-map or residual pixels; every result transaction also
// reports the iteration count, stop reason and final residual peak of the last run. The
// residual map, beam and clean map live in three single-read, single-write memories of
// ROWS*COLS words each, and all work is one pixel per cycle through them. A run begins with
// the clean-map clearing pass (done together with the beam peak search) and the first
// residual peak search, and then makes one subtraction pass per CLEAN iteration: the
// subtraction pass walks the whole residual memory once, and the component is found by a
// 48-step bit-serial divider. A finished result sits in an output register, so the next
// transaction is taken while the previous result is still stalled.
module hogbom_clean_deconvolver #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hcd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hcd_pkg::*;

  localparam int NPIX = ROWS * COLS;
  localparam int AW   = $clog2(NPIX);
  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int SW   = AW + 32;
  localparam int CMPW = AW + 41;
  localparam logic signed [RW+1:0] ROWS_S = (RW+2)'(ROWS);
  localparam logic signed [CW+1:0] COLS_S = (CW+2)'(COLS);
  localparam logic signed [AW+1:0] COLS_A = (AW+2)'(COLS);

  // Pixel memories.
  logic signed [31:0] res_mem  [NPIX];
  logic signed [31:0] beam_mem [NPIX];
  logic signed [31:0] comp_mem [NPIX];
  logic signed [31:0] res_rd_r, beam_rd_r, comp_rd_r;
  logic [AW-1:0]      res_raddr, beam_raddr, comp_raddr;
  logic [AW-1:0]      res_waddr, beam_waddr, comp_waddr;
  logic signed [31:0] res_wdata, beam_wdata, comp_wdata;
  logic               res_we, beam_we, comp_we;

  // Control and status.
  hcd_state_t         state_r, state_nxt;
  hcd_sweep_t         mode_r, mode_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               inside_r, inside_nxt;
  logic signed [31:0] res_pix_r, res_pix_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [15:0]        gain_r, gain_nxt;
  logic [30:0]        noise_r, noise_nxt;
  logic [15:0]        maxit_r, maxit_nxt;
  logic [7:0]         factor_r, factor_nxt;
  logic               posonly_r, posonly_nxt;

  logic [15:0]        last_iter_r, last_iter_nxt;
  logic [2:0]         last_stop_r, last_stop_nxt;
  logic [RW-1:0]      last_row_r, last_row_nxt;
  logic [CW-1:0]      last_col_r, last_col_nxt;
  logic signed [31:0] last_val_r, last_val_nxt;

  // Sweep pipeline.
  logic               issue_r, issue_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic [RW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]      s1_k_r, s1_k_nxt;
  logic [RW-1:0]      s1_i_r, s1_i_nxt;
  logic [CW-1:0]      s1_j_r, s1_j_nxt;
  logic               s1_inb_r, s1_inb_nxt;
  logic               s2_valid_r, s2_valid_nxt;
  logic [AW-1:0]      s2_k_r, s2_k_nxt;
  logic [RW-1:0]      s2_i_r, s2_i_nxt;
  logic [CW-1:0]      s2_j_r, s2_j_nxt;
  logic               s2_inb_r, s2_inb_nxt;
  logic signed [31:0] s2_res_r, s2_res_nxt;
  logic signed [63:0] s2_prod_r, s2_prod_nxt;

  // Iteration state.
  logic [SW-1:0]      sum_r, sum_nxt;
  logic signed [31:0] bv_r, bv_nxt;
  logic [RW-1:0]      brow_r, brow_nxt;
  logic [CW-1:0]      bcol_r, bcol_nxt;
  logic signed [31:0] mv_r, mv_nxt;
  logic [AW-1:0]      mk_r, mk_nxt;
  logic [RW-1:0]      mrow_r, mrow_nxt;
  logic [CW-1:0]      mcol_r, mcol_nxt;
  logic signed [33:0] prev_r, prev_nxt;
  logic [15:0]        iter_r, iter_nxt;
  logic [2:0]         stop_r, stop_nxt;
  logic [CMPW-1:0]    lhs_r, lhs_nxt;
  logic [CMPW-1:0]    rhs_r, rhs_nxt;
  logic signed [47:0] gprod_r, gprod_nxt;
  logic signed [RW+1:0] offr_r, offr_nxt;
  logic signed [CW+1:0] offc_r, offc_nxt;
  logic signed [AW+1:0] delta_r, delta_nxt;
  logic signed [31:0] coef_r, coef_nxt;

  // Combinational helpers.
  logic               in_acc;
  logic               out_free;
  logic [AW-1:0]      in_k;
  logic               in_inside;
  logic signed [RW+1:0] di;
  logic signed [CW+1:0] dj;
  logic               inb0;
  logic signed [AW+1:0] baddr_s;
  logic signed [63:0] t_round, t_q, diff64;
  logic signed [31:0] new_res;
  logic [31:0]        amag;
  logic [33:0]        prev_mag;
  logic               same_sign;
  logic signed [RW+1:0] offr_c;
  logic signed [CW+1:0] offc_c;
  logic               pipe_empty;

  // Divider and peak tracker hookups.
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;
  logic               trk_clr, trk_vld;
  logic signed [31:0] trk_val, trk_best_val;
  logic [AW-1:0]      trk_k, trk_best_k;
  logic [RW-1:0]      trk_row, trk_best_row;
  logic [CW-1:0]      trk_col, trk_best_col;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign in_k      = AW'(32'(in_data.row) * COLS + 32'(in_data.col));
  assign in_inside = (32'(in_data.row) < 32'(ROWS)) && (32'(in_data.col) < 32'(COLS));

  // Beam pixel under residual pixel (i, j) for the current peak offset.
  assign di      = $signed({2'b00, i_r}) + offr_r;
  assign dj      = $signed({2'b00, j_r}) + offc_r;
  assign inb0    = !di[RW+1] && (di < ROWS_S) && !dj[CW+1] && (dj < COLS_S);
  assign baddr_s = $signed({2'b00, k_r}) + delta_r;

  // Beam term rounded toward zero, then the saturated subtraction.
  assign t_round = s2_prod_r + (s2_prod_r[63] ? 64'sd65535 : 64'sd0);
  assign t_q     = t_round >>> 16;
  assign diff64  = 64'(s2_res_r) - t_q;
  assign new_res = s2_inb_r ? sat32(diff64) : s2_res_r;

  assign amag      = mag32(mv_r);
  assign prev_mag  = prev_r[33] ? 34'(-prev_r) : 34'(prev_r);
  assign same_sign = ((mv_r > 0) && (prev_r > 0)) || (mv_r[31] && prev_r[33]);
  assign offr_c    = $signed({2'b00, brow_r}) - $signed({2'b00, mrow_r});
  assign offc_c    = $signed({2'b00, bcol_r}) - $signed({2'b00, mcol_r});
  assign pipe_empty = !issue_r && !s1_valid_r && !s2_valid_r;

  assign div_dvd = gprod_r[47] ? DVD_W'(-gprod_r) : DVD_W'(gprod_r);
  assign div_dvs = mag32(bv_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    inside_nxt    = inside_r;
    res_pix_nxt   = res_pix_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    gain_nxt      = gain_r;
    noise_nxt     = noise_r;
    maxit_nxt     = maxit_r;
    factor_nxt    = factor_r;
    posonly_nxt   = posonly_r;
    last_iter_nxt = last_iter_r;
    last_stop_nxt = last_stop_r;
    last_row_nxt  = last_row_r;
    last_col_nxt  = last_col_r;
    last_val_nxt  = last_val_r;
    issue_nxt     = issue_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    s1_valid_nxt  = 1'b0;
    s1_k_nxt      = k_r;
    s1_i_nxt      = i_r;
    s1_j_nxt      = j_r;
    s1_inb_nxt    = inb0;
    s2_valid_nxt  = s1_valid_r && (mode_r == SW_SUB);
    s2_k_nxt      = s1_k_r;
    s2_i_nxt      = s1_i_r;
    s2_j_nxt      = s1_j_r;
    s2_inb_nxt    = s1_inb_r;
    s2_res_nxt    = res_rd_r;
    s2_prod_nxt   = 64'(beam_rd_r) * 64'(coef_r);
    sum_nxt       = sum_r;
    bv_nxt        = bv_r;
    brow_nxt      = brow_r;
    bcol_nxt      = bcol_r;
    mv_nxt        = mv_r;
    mk_nxt        = mk_r;
    mrow_nxt      = mrow_r;
    mcol_nxt      = mcol_r;
    prev_nxt      = prev_r;
    iter_nxt      = iter_r;
    stop_nxt      = stop_r;
    lhs_nxt       = lhs_r;
    rhs_nxt       = rhs_r;
    gprod_nxt     = gprod_r;
    offr_nxt      = offr_r;
    offc_nxt      = offc_r;
    delta_nxt     = delta_r;
    coef_nxt      = coef_r;

    div_start  = 1'b0;
    trk_clr    = 1'b0;
    res_raddr  = addr_r;
    comp_raddr = addr_r;
    beam_raddr = k_r;
    res_we     = 1'b0;
    res_waddr  = s2_k_r;
    res_wdata  = new_res;
    beam_we    = 1'b0;
    beam_waddr = in_k;
    beam_wdata = in_data.pixel_in;
    comp_we    = 1'b0;
    comp_waddr = k_r;
    comp_wdata = '0;

    // Configuration writes are taken in any cycle.
    if (cfg_valid) begin
      case (cfg_index)
        REG_LOOP_GAIN: gain_nxt    = cfg_data[15:0];
        REG_NOISE:     noise_nxt   = cfg_data[30:0];
        REG_MAX_ITER:  maxit_nxt   = cfg_data[15:0];
        REG_AVG_FACT:  factor_nxt  = cfg_data[7:0];
        REG_POS_ONLY:  posonly_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        res_raddr  = in_k;
        comp_raddr = in_k;
        if (in_acc) begin
          cmd_nxt     = in_data.command;
          addr_nxt    = in_k;
          inside_nxt  = in_inside;
          res_pix_nxt = '0;
          state_nxt   = ST_FIN;
          case (in_data.command)
            CMD_WR_MAP: begin
              res_we    = in_inside;
              res_waddr = in_k;
              res_wdata = in_data.pixel_in;
            end
            CMD_WR_BEAM: begin
              beam_we = in_inside;
            end
            CMD_RUN: begin
              // Beam peak search, clearing the clean map on the way.
              state_nxt = ST_SWEEP;
              mode_nxt  = SW_BEAM;
              issue_nxt = 1'b1;
              k_nxt     = '0;
              i_nxt     = '0;
              j_nxt     = '0;
              trk_clr   = 1'b1;
            end
            CMD_RD_CLEAN: state_nxt = ST_RD;
            CMD_RD_RES:   state_nxt = ST_RD;
            default: ;
          endcase
        end
      end

      ST_RD: begin
        if (!inside_r) begin
          res_pix_nxt = '0;
        end else if (cmd_r == CMD_RD_CLEAN) begin
          res_pix_nxt = comp_rd_r;
        end else begin
          res_pix_nxt = res_rd_r;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.pixel_out       = res_pix_r;
          out_data_nxt.iterations_done = last_iter_r;
          out_data_nxt.stop_reason     = last_stop_r;
          out_data_nxt.peak_row        = 6'(last_row_r);
          out_data_nxt.peak_col        = 6'(last_col_r);
          out_data_nxt.peak_value      = last_val_r;
          state_nxt                    = ST_IDLE;
        end
      end

      ST_SWEEP: begin
        res_raddr = k_r;
        if (mode_r == SW_SUB) begin
          beam_raddr = inb0 ? baddr_s[AW-1:0] : '0;
        end
        if (issue_r) begin
          s1_valid_nxt = 1'b1;
          if (mode_r == SW_BEAM) begin
            comp_we    = 1'b1;
            comp_waddr = k_r;
          end
          if (k_r == AW'(NPIX - 1)) begin
            issue_nxt = 1'b0;
          end else begin
            k_nxt = k_r + 1'b1;
            if (j_r == CW'(COLS - 1)) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
        // The mean test uses the residual as it was before subtraction.
        if (s1_valid_r && (mode_r == SW_SUB)) begin
          sum_nxt = sum_r + SW'(mag32(res_rd_r));
        end
        if (s2_valid_r) begin
          res_we    = 1'b1;
          res_waddr = s2_k_r;
          res_wdata = new_res;
        end
        if (pipe_empty) begin
          case (mode_r)
            SW_BEAM: begin
              bv_nxt    = trk_best_val;
              brow_nxt  = trk_best_row;
              bcol_nxt  = trk_best_col;
              mode_nxt  = SW_MAP;
              issue_nxt = 1'b1;
              k_nxt     = '0;
              i_nxt     = '0;
              j_nxt     = '0;
              trk_clr   = 1'b1;
            end
            SW_MAP: begin
              mv_nxt   = trk_best_val;
              mk_nxt   = trk_best_k;
              mrow_nxt = trk_best_row;
              mcol_nxt = trk_best_col;
              prev_nxt = $signed(34'(mag32(trk_best_val)) + 34'(Q_ONE));
              sum_nxt  = '0;
              iter_nxt = '0;
              if (bv_r == 32'sd0) begin
                stop_nxt  = STOP_BEAM_ZERO;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_CHK0;
              end
            end
            SW_SUB: begin
              iter_nxt  = iter_r + 1'b1;
              prev_nxt  = 34'(mv_r);
              mv_nxt    = trk_best_val;
              mk_nxt    = trk_best_k;
              mrow_nxt  = trk_best_row;
              mcol_nxt  = trk_best_col;
              state_nxt = ST_CHK0;
            end
            default: state_nxt = ST_CHK0;
          endcase
        end
      end

      ST_CHK0: begin
        lhs_nxt   = CMPW'(CMPW'(amag) * CMPW'(NPIX));
        rhs_nxt   = CMPW'(CMPW'(factor_r) * CMPW'(sum_r));
        state_nxt = ST_CHK1;
      end

      ST_CHK1: begin
        state_nxt = ST_DONE;
        if (lhs_r < rhs_r) begin
          stop_nxt = STOP_AVERAGE;
        end else if (amag < 32'(noise_r)) begin
          stop_nxt = STOP_NOISE;
        end else if (iter_r >= maxit_r) begin
          stop_nxt = STOP_ITER;
        end else if (!((prev_mag > 34'(amag)) || same_sign)) begin
          stop_nxt = STOP_NOT_FALL;
        end else begin
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        gprod_nxt = 48'(mv_r) * 48'($signed({1'b0, gain_r}));
        offr_nxt  = offr_c;
        offc_nxt  = offc_c;
        delta_nxt = (AW+2)'(offr_c) * COLS_A + (AW+2)'(offc_c);
        state_nxt = ST_DIVS;
      end

      ST_DIVS: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end

      ST_DIVW: begin
        if (div_done) begin
          // Sign of the quotient, saturated to 32 bits.
          if (gprod_r[47] ^ bv_r[31]) begin
            if (div_q > DVD_W'(64'h8000_0000)) begin
              coef_nxt = 32'sh8000_0000;
            end else begin
              coef_nxt = 32'(-div_q);
            end
          end else begin
            if (div_q > DVD_W'(64'h7FFF_FFFF)) begin
              coef_nxt = 32'sh7FFF_FFFF;
            end else begin
              coef_nxt = div_q[31:0];
            end
          end
          state_nxt = ST_ADDRD;
        end
      end

      ST_ADDRD: begin
        comp_raddr = mk_r;
        state_nxt  = ST_ADDWR;
      end

      ST_ADDWR: begin
        comp_we    = 1'b1;
        comp_waddr = mk_r;
        comp_wdata = sat32(64'(comp_rd_r) + 64'(coef_r));
        mode_nxt   = SW_SUB;
        issue_nxt  = 1'b1;
        k_nxt      = '0;
        i_nxt      = '0;
        j_nxt      = '0;
        sum_nxt    = '0;
        trk_clr    = 1'b1;
        state_nxt  = ST_SWEEP;
      end

      ST_DONE: begin
        last_iter_nxt = iter_r;
        last_stop_nxt = stop_r;
        last_row_nxt  = mrow_r;
        last_col_nxt  = mcol_r;
        last_val_nxt  = mv_r;
        res_pix_nxt   = '0;
        state_nxt     = ST_FIN;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Peak tracker input: read data during the search passes, the updated
  // residual during the subtraction pass.
  always_comb begin
    if (mode_r == SW_SUB) begin
      trk_vld = s2_valid_r;
      trk_val = new_res;
      trk_k   = s2_k_r;
      trk_row = s2_i_r;
      trk_col = s2_j_r;
    end else begin
      trk_vld = s1_valid_r;
      trk_val = (mode_r == SW_BEAM) ? beam_rd_r : res_rd_r;
      trk_k   = s1_k_r;
      trk_row = s1_i_r;
      trk_col = s1_j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    res_rd_r <= res_mem[res_raddr];
  end

  always_ff @(posedge clk) begin
    if (beam_we) begin
      beam_mem[beam_waddr] <= beam_wdata;
    end
    beam_rd_r <= beam_mem[beam_raddr];
  end

  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[comp_waddr] <= comp_wdata;
    end
    comp_rd_r <= comp_mem[comp_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      gain_r      <= 16'd6554;
      noise_r     <= '0;
      maxit_r     <= 16'd100;
      factor_r    <= '0;
      posonly_r   <= 1'b0;
      last_iter_r <= '0;
      last_stop_r <= '0;
      last_row_r  <= '0;
      last_col_r  <= '0;
      last_val_r  <= '0;
      mode_r      <= SW_BEAM;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      gain_r      <= gain_nxt;
      noise_r     <= noise_nxt;
      maxit_r     <= maxit_nxt;
      factor_r    <= factor_nxt;
      posonly_r   <= posonly_nxt;
      last_iter_r <= last_iter_nxt;
      last_stop_r <= last_stop_nxt;
      last_row_r  <= last_row_nxt;
      last_col_r  <= last_col_nxt;
      last_val_r  <= last_val_nxt;
      mode_r      <= mode_nxt;
    end
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    inside_r   <= inside_nxt;
    res_pix_r  <= res_pix_nxt;
    out_data_r <= out_data_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    s1_k_r     <= s1_k_nxt;
    s1_i_r     <= s1_i_nxt;
    s1_j_r     <= s1_j_nxt;
    s1_inb_r   <= s1_inb_nxt;
    s2_k_r     <= s2_k_nxt;
    s2_i_r     <= s2_i_nxt;
    s2_j_r     <= s2_j_nxt;
    s2_inb_r   <= s2_inb_nxt;
    s2_res_r   <= s2_res_nxt;
    s2_prod_r  <= s2_prod_nxt;
    sum_r      <= sum_nxt;
    bv_r       <= bv_nxt;
    brow_r     <= brow_nxt;
    bcol_r     <= bcol_nxt;
    mv_r       <= mv_nxt;
    mk_r       <= mk_nxt;
    mrow_r     <= mrow_nxt;
    mcol_r     <= mcol_nxt;
    prev_r     <= prev_nxt;
    iter_r     <= iter_nxt;
    stop_r     <= stop_nxt;
    lhs_r      <= lhs_nxt;
    rhs_r      <= rhs_nxt;
    gprod_r    <= gprod_nxt;
    offr_r     <= offr_nxt;
    offc_r     <= offc_nxt;
    delta_r    <= delta_nxt;
    coef_r     <= coef_nxt;
  end

  hcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  hcd_peak #(
    .AW (AW),
    .RW (RW),
    .CW (CW)
  ) u_peak (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (trk_clr),
    .vld      (trk_vld),
    .pos_only (posonly_r),
    .val      (trk_val),
    .k        (trk_k),
    .row      (trk_row),
    .col      (trk_col),
    .best_val (trk_best_val),
    .best_k   (trk_best_k),
    .best_row (trk_best_row),
    .best_col (trk_best_col)
  );

endmodule

// ===== sv/hcd_checker.sv =====
module hcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hcd_pkg::out_item_t  out_data
);
  import hcd_pkg::*;

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // A run with a zero beam peak performs no iterations.
  a_beam_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.stop_reason == STOP_BEAM_ZERO) |-> out_data.iterations_done == 16'd0)
    else $error("iterations reported with zero beam peak");

endmodule

bind hogbom_clean_deconvolver hcd_checker u_hcd_checker (.*);
